// ===== hdl/ntp_seconds_to_local_calendar_unit_defines.svh =====
// Assertion macros for the NTP seconds to local calendar unit.
// Used by the top level only; expects clock and reset in scope.
`ifndef NTP_SECONDS_TO_LOCAL_CALENDAR_UNIT_DEFINES_SVH
`define NTP_SECONDS_TO_LOCAL_CALENDAR_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define NTPC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Same-cycle implication
`define NTPC_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ntpc_pkg.sv =====
// Shared types, constants and helper functions for the NTP calendar unit.
// No dependencies; imported by every module of the block.
package ntpc_pkg;

   // pipeline depth: input register, five work stages, output register
   localparam int unsigned NUM_STAGES = 7;

   // accepted SNTP modes
   localparam logic [2:0] MODE_SERVER    = 3'd4;
   localparam logic [2:0] MODE_BROADCAST = 3'd5;

   // register map (index = paddr[2])
   typedef enum logic [0:0] {
      REG_UTC_OFFSET = 1'b0,
      REG_DAYLIGHT   = 1'b1
   } ntpc_reg_type;

   typedef struct packed {
      logic signed [4:0] utc_offset;
      logic              daylight;
   } ntpc_cfg_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } ntpc_flow_type;

   // seconds from 1900-01-01 to 1970-01-01
   localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;

   // seconds/86400 = (seconds>>7)/675, done as multiply by ceil(2^35/675)
   localparam logic [25:0] DAY_RECIP   = 26'd50903317;
   localparam int unsigned DAY_SHIFT   = 35;
   localparam logic [16:0] DAY_SECS    = 17'd86400;

   // rem/3600 and rem/60 for rem below 86400
   localparam logic [15:0] HOUR_RECIP  = 16'd37283;
   localparam int unsigned HOUR_SHIFT  = 27;
   localparam logic [17:0] MIN_RECIP   = 18'd139811;
   localparam int unsigned MIN_SHIFT   = 23;
   localparam logic [5:0]  MIN_SECS    = 6'd60;

   // four-year cycles counted from 1968-01-01
   localparam logic [15:0] CYCLE_RECIP     = 16'd45934;
   localparam int unsigned CYCLE_SHIFT     = 26;
   localparam logic [10:0] CYCLE_DAYS      = 11'd1461;
   localparam logic [15:0] CYCLE_OFFSET    = 16'd731;
   localparam logic [11:0] CYCLE_BASE_YEAR = 12'd1968;
   localparam logic [10:0] LEAP_YEAR_DAYS  = 11'd366;
   localparam logic [10:0] YEAR_DAYS       = 11'd365;

   // 2100 has no Feb 29; from its March 1 on a phantom day is inserted
   localparam logic [15:0] MARCH_2100_DAY  = 16'd47541;
   localparam logic [11:0] NONLEAP_CENTURY = 12'd2100;
   localparam logic [8:0]  MARCH_LEAP_YDAY = 9'd60;

   localparam logic [6:0] HOURS_PER_DAY = 7'd24;
   localparam logic [3:0] JANUARY       = 4'd1;
   localparam logic [3:0] FEBRUARY      = 4'd2;
   localparam logic [3:0] MARCH         = 4'd3;
   localparam logic [3:0] DECEMBER      = 4'd12;

   // value mod 7 by folding octal digits (8 = 1 mod 7)
   function automatic logic [2:0] mod7(input logic [15:0] value);
      logic [5:0] digit_sum;
      logic [3:0] fold;
      begin
         digit_sum = 6'(value[2:0]) + 6'(value[5:3]) + 6'(value[8:6])
                   + 6'(value[11:9]) + 6'(value[14:12]) + 6'(value[15]);
         fold = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
         if (fold >= 4'd7) begin
            fold = fold - 4'd7;
         end
         return fold[2:0];
      end
   endfunction

   // day of year on which a month starts, counted from 0
   function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
      logic [8:0] start;
      begin
         case (month)
            4'd1:    start = 9'd0;
            4'd2:    start = 9'd31;
            4'd3:    start = 9'd59;
            4'd4:    start = 9'd90;
            4'd5:    start = 9'd120;
            4'd6:    start = 9'd151;
            4'd7:    start = 9'd181;
            4'd8:    start = 9'd212;
            4'd9:    start = 9'd243;
            4'd10:   start = 9'd273;
            4'd11:   start = 9'd304;
            4'd12:   start = 9'd334;
            default: start = 9'd0;
         endcase
         if (month >= MARCH) begin
            start = start + 9'(leap);
         end
         return start;
      end
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      begin
         case (month)
            4'd2:    len = 5'd28 + 5'(leap);
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
         endcase
         return len;
      end
   endfunction

endpackage

// ===== hdl/ntp_seconds_to_local_calendar_unit.sv =====
// Top level of the NTP seconds to local calendar unit.
// Depends on ntpc_pkg, ntpc_csr, ntpc_flow, ntpc_datapath and the defines header.

// Converts the mode and transmit seconds of an SNTP reply into a local calendar
// date and time. Server and broadcast replies (mode 4 or 5) give accepted = 1 with
// the date shifted by the zone offset plus daylight saving hour; any other mode gives
// an all-zero item. Weekday and yearday are UTC. Throughput is one item per clock
// while rsp_tready is high. A result passes through the seven registers of the
// pipeline (input, whole days, seconds of day with four-year cycle, hour and
// minute, year and day of year, month with local hour, output). Stalled stages
// collapse bubbles, so req_tready stays high while any stage is empty. There is no
// clearing pass after reset. Registers: 0x0 utc_offset_hours (5-bit signed),
// 0x4 daylight_saving_hours (1 bit); write them only while the unit is idle.
`include "ntp_seconds_to_local_calendar_unit_defines.svh"

module ntp_seconds_to_local_calendar_unit
   import ntpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   // reply items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] ntp_seconds
   input  logic [2:0]  req_tuser,   // [2:0] mode_bits
   // calendar items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [11:0] year, [15:12] month, [20:16] day,
                                    // [25:21] hour, [31:26] minute, [37:32] second,
                                    // [40:38] weekday, [49:41] yearday, [55:50] zero
   output logic        rsp_tuser    // [0] accepted
);

   ntpc_cfg_type  cfg;
   ntpc_flow_type flow;
   logic          out_accepted;
   logic [11:0]   out_year;
   logic [3:0]    out_month;
   logic [4:0]    out_day;
   logic [4:0]    out_hour;
   logic [5:0]    out_minute;
   logic [5:0]    out_second;
   logic [2:0]    out_weekday;
   logic [8:0]    out_yearday;

   ntpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ntpc_flow u_flow (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .flow       (flow)
   );

   ntpc_datapath u_datapath (
      .clock          (clock),
      .flow           (flow),
      .cfg            (cfg),
      .in_mode_bits   (req_tuser),
      .in_ntp_seconds (req_tdata),
      .out_accepted   (out_accepted),
      .out_year       (out_year),
      .out_month      (out_month),
      .out_day        (out_day),
      .out_hour       (out_hour),
      .out_minute     (out_minute),
      .out_second     (out_second),
      .out_weekday    (out_weekday),
      .out_yearday    (out_yearday)
   );

   // result packing, first field lowest
   assign rsp_tdata = {6'd0, out_yearday, out_weekday, out_second, out_minute,
                       out_hour, out_day, out_month, out_year};
   assign rsp_tuser = out_accepted;

   // a free output slot must propagate back to the input side
   `NTPC_ASSERT_IMPLIES(a_ready_chain, rsp_tready, req_tready, "input stalled with free output")
   `NTPC_ASSERT_IMPLIES(a_reject_zero, rsp_tvalid && !out_accepted, rsp_tdata == 56'd0,
      "rejected item carries nonzero fields")
   `NTPC_ASSERT_IMPLIES(a_time_range, rsp_tvalid && out_accepted,
      out_hour < 5'd24 && out_minute < 6'd60 && out_second < 6'd60 && out_weekday < 3'd7,
      "time of day out of range")
   `NTPC_ASSERT_IMPLIES(a_date_range, rsp_tvalid && out_accepted,
      out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1
         && out_year >= 12'd1969 && out_year <= 12'd2106,
      "calendar date out of range")
   `NTPC_ASSERT_ALWAYS(a_yearday_range, !rsp_tvalid || out_yearday <= 9'd365,
      "day of year out of range")

endmodule

// ===== hdl/ntpc_csr.sv =====
// Configuration registers (zone offset, daylight saving) behind an APB-style port.
// Depends on ntpc_pkg.
module ntpc_csr
   import ntpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready,
   output ntpc_cfg_type cfg
);

   ntpc_cfg_type cfg_ff;
   ntpc_cfg_type cfg_in;
   ntpc_reg_type reg_sel;
   logic         wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = ntpc_reg_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_UTC_OFFSET: cfg_in.utc_offset = csr_pwdata[4:0];
            REG_DAYLIGHT:   cfg_in.daylight   = csr_pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, offset sign-extended
   always_comb begin
      case (reg_sel)
         REG_UTC_OFFSET: csr_prdata = {{27{cfg_ff.utc_offset[4]}}, cfg_ff.utc_offset};
         REG_DAYLIGHT:   csr_prdata = {31'd0, cfg_ff.daylight};
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/ntpc_flow.sv =====
// Pipeline occupancy and stall control: one valid bit per stage, bubbles collapse.
// Depends on ntpc_pkg.
module ntpc_flow
   import ntpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output ntpc_flow_type flow
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] room;

   // a stage can load when empty or when its item moves on
   always_comb begin
      room[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         room[k] = !valid_ff[k] || room[k+1];
      end
   end

   always_comb begin
      valid_in[0] = room[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = room[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign flow.load  = room;
   assign req_tready = room[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

endmodule

// ===== hdl/ntpc_datapath.sv =====
// Payload pipeline: NTP seconds to UTC split, calendar date, local hour rollover.
// Depends on ntpc_pkg; stage loads come from ntpc_flow.
module ntpc_datapath
   import ntpc_pkg::*;
(
   input  logic          clock,
   input  ntpc_flow_type flow,
   input  ntpc_cfg_type  cfg,
   input  logic [2:0]    in_mode_bits,
   input  logic [31:0]   in_ntp_seconds,
   output logic          out_accepted,
   output logic [11:0]   out_year,
   output logic [3:0]    out_month,
   output logic [4:0]    out_day,
   output logic [4:0]    out_hour,
   output logic [5:0]    out_minute,
   output logic [5:0]    out_second,
   output logic [2:0]    out_weekday,
   output logic [8:0]    out_yearday
);

   // stage 0: input register
   logic        s0_acc_ff,  s0_acc_in;
   logic [31:0] s0_ntp_ff;

   assign s0_acc_in = (in_mode_bits == MODE_SERVER) || (in_mode_bits == MODE_BROADCAST);

   always_ff @(posedge clock) begin
      if (flow.load[0]) begin
         s0_acc_ff <= s0_acc_in;
         s0_ntp_ff <= in_ntp_seconds;
      end
   end

   // stage 1: Unix seconds and whole days
   logic        s1_acc_ff;
   logic [31:0] s1_unix_ff, s1_unix_in;
   logic [15:0] s1_days_ff, s1_days_in;
   logic [50:0] s1_day_prod;

   assign s1_unix_in  = s0_ntp_ff - NTP_UNIX_OFFSET;
   assign s1_day_prod = 51'(s1_unix_in[31:7]) * 51'(DAY_RECIP);
   assign s1_days_in  = s1_day_prod[DAY_SHIFT+15:DAY_SHIFT];

   always_ff @(posedge clock) begin
      if (flow.load[1]) begin
         s1_acc_ff  <= s0_acc_ff;
         s1_unix_ff <= s1_unix_in;
         s1_days_ff <= s1_days_in;
      end
   end

   // stage 2: seconds of day, weekday, four-year cycle number
   logic        s2_acc_ff;
   logic [16:0] s2_rem_ff,  s2_rem_in;
   logic [2:0]  s2_wday_ff, s2_wday_in;
   logic [15:0] s2_dp_ff,   s2_dp_in;
   logic [5:0]  s2_cyc_ff,  s2_cyc_in;
   logic [31:0] s2_day_secs;
   logic [31:0] s2_cyc_prod;

   assign s2_day_secs = 32'(s1_days_ff) * 32'(DAY_SECS);
   assign s2_rem_in   = 17'(s1_unix_ff - s2_day_secs);
   assign s2_wday_in  = mod7(s1_days_ff + 16'd4);
   // days from 1968-01-01, with a phantom Feb 29 in 2100
   assign s2_dp_in    = s1_days_ff + CYCLE_OFFSET
                      + 16'(s1_days_ff >= MARCH_2100_DAY);
   assign s2_cyc_prod = 32'(s2_dp_in) * 32'(CYCLE_RECIP);
   assign s2_cyc_in   = s2_cyc_prod[CYCLE_SHIFT+5:CYCLE_SHIFT];

   always_ff @(posedge clock) begin
      if (flow.load[2]) begin
         s2_acc_ff  <= s1_acc_ff;
         s2_rem_ff  <= s2_rem_in;
         s2_wday_ff <= s2_wday_in;
         s2_dp_ff   <= s2_dp_in;
         s2_cyc_ff  <= s2_cyc_in;
      end
   end

   // stage 3: hour, minute of day, day within the four-year cycle
   logic        s3_acc_ff;
   logic [16:0] s3_rem_ff;
   logic [2:0]  s3_wday_ff;
   logic [5:0]  s3_cyc_ff;
   logic [4:0]  s3_hr_ff,  s3_hr_in;
   logic [10:0] s3_mod_ff, s3_mod_in;
   logic [10:0] s3_r_ff,   s3_r_in;
   logic [32:0] s3_hr_prod;
   logic [34:0] s3_mod_prod;
   logic [15:0] s3_cyc_days;

   assign s3_hr_prod  = 33'(s2_rem_ff) * 33'(HOUR_RECIP);
   assign s3_hr_in    = s3_hr_prod[HOUR_SHIFT+4:HOUR_SHIFT];
   assign s3_mod_prod = 35'(s2_rem_ff) * 35'(MIN_RECIP);
   assign s3_mod_in   = s3_mod_prod[MIN_SHIFT+10:MIN_SHIFT];
   assign s3_cyc_days = 16'(s2_cyc_ff) * 16'(CYCLE_DAYS);
   assign s3_r_in     = 11'(s2_dp_ff - s3_cyc_days);

   always_ff @(posedge clock) begin
      if (flow.load[3]) begin
         s3_acc_ff  <= s2_acc_ff;
         s3_rem_ff  <= s2_rem_ff;
         s3_wday_ff <= s2_wday_ff;
         s3_cyc_ff  <= s2_cyc_ff;
         s3_hr_ff   <= s3_hr_in;
         s3_mod_ff  <= s3_mod_in;
         s3_r_ff    <= s3_r_in;
      end
   end

   // stage 4: second, minute, year and day of year
   logic        s4_acc_ff;
   logic [2:0]  s4_wday_ff;
   logic [4:0]  s4_hr_ff;
   logic [5:0]  s4_sec_ff,  s4_sec_in;
   logic [5:0]  s4_min_ff,  s4_min_in;
   logic [11:0] s4_year_ff, s4_year_in;
   logic [8:0]  s4_yd_ff,   s4_yd_in;
   logic [1:0]  s4_yo;
   logic [10:0] s4_after_leap;

   assign s4_sec_in = 6'(s3_rem_ff - 17'(s3_mod_ff) * 17'(MIN_SECS));
   assign s4_min_in = 6'(s3_mod_ff - 11'(s3_hr_ff) * 11'(MIN_SECS));

   // first year of each cycle is the leap year
   always_comb begin
      s4_after_leap = s3_r_ff - LEAP_YEAR_DAYS;
      if (s3_r_ff < LEAP_YEAR_DAYS) begin
         s4_yo    = 2'd0;
         s4_yd_in = s3_r_ff[8:0];
      end else if (s4_after_leap < YEAR_DAYS) begin
         s4_yo    = 2'd1;
         s4_yd_in = s4_after_leap[8:0];
      end else if (s4_after_leap < 11'(2 * YEAR_DAYS)) begin
         s4_yo    = 2'd2;
         s4_yd_in = 9'(s4_after_leap - YEAR_DAYS);
      end else begin
         s4_yo    = 2'd3;
         s4_yd_in = 9'(s4_after_leap - 11'(2 * YEAR_DAYS));
      end
   end

   assign s4_year_in = CYCLE_BASE_YEAR + 12'({s3_cyc_ff, 2'b00}) + 12'(s4_yo);

   always_ff @(posedge clock) begin
      if (flow.load[4]) begin
         s4_acc_ff  <= s3_acc_ff;
         s4_wday_ff <= s3_wday_ff;
         s4_hr_ff   <= s3_hr_ff;
         s4_sec_ff  <= s4_sec_in;
         s4_min_ff  <= s4_min_in;
         s4_year_ff <= s4_year_in;
         s4_yd_ff   <= s4_yd_in;
      end
   end

   // stage 5: month and day, true day of year, local hour before wrap
   logic        s5_acc_ff;
   logic [2:0]  s5_wday_ff;
   logic [5:0]  s5_sec_ff;
   logic [5:0]  s5_min_ff;
   logic [11:0] s5_year_ff;
   logic [3:0]  s5_month_ff, s5_month_in;
   logic [4:0]  s5_mday_ff,  s5_mday_in;
   logic [8:0]  s5_yday_ff,  s5_yday_in;
   logic [6:0]  s5_hour_ff,  s5_hour_in;
   logic        s5_leap_cyc;

   // 2100 is treated as leap here; the phantom day keeps months right
   assign s5_leap_cyc = (s4_year_ff[1:0] == 2'b00);

   always_comb begin
      s5_month_in = JANUARY;
      for (int m = 2; m <= 12; m++) begin
         if (s4_yd_ff >= month_start(4'(m), s5_leap_cyc)) begin
            s5_month_in = 4'(m);
         end
      end
   end

   assign s5_mday_in = 5'(s4_yd_ff - month_start(s5_month_in, s5_leap_cyc) + 9'd1);
   assign s5_yday_in = s4_yd_ff - 9'((s4_year_ff == NONLEAP_CENTURY)
                                     && (s4_yd_ff >= MARCH_LEAP_YDAY));
   // two's complement, range -16..39
   assign s5_hour_in = {2'b00, s4_hr_ff} + {{2{cfg.utc_offset[4]}}, cfg.utc_offset}
                     + {6'd0, cfg.daylight};

   always_ff @(posedge clock) begin
      if (flow.load[5]) begin
         s5_acc_ff   <= s4_acc_ff;
         s5_wday_ff  <= s4_wday_ff;
         s5_sec_ff   <= s4_sec_ff;
         s5_min_ff   <= s4_min_ff;
         s5_year_ff  <= s4_year_ff;
         s5_month_ff <= s5_month_in;
         s5_mday_ff  <= s5_mday_in;
         s5_yday_ff  <= s5_yday_in;
         s5_hour_ff  <= s5_hour_in;
      end
   end

   // stage 6: hour wrap with one-day date step, result register
   logic        s6_acc_ff;
   logic [11:0] s6_year_ff,  s6_year_in;
   logic [3:0]  s6_month_ff, s6_month_in;
   logic [4:0]  s6_mday_ff,  s6_mday_in;
   logic [4:0]  s6_hour_ff,  s6_hour_in;
   logic [5:0]  s6_min_ff,   s6_min_in;
   logic [5:0]  s6_sec_ff,   s6_sec_in;
   logic [2:0]  s6_wday_ff,  s6_wday_in;
   logic [8:0]  s6_yday_ff,  s6_yday_in;
   logic        s6_leap;
   logic [3:0]  s6_prev_month;
   logic [6:0]  s6_hour_wrap;

   assign s6_leap       = (s5_year_ff[1:0] == 2'b00) && (s5_year_ff != NONLEAP_CENTURY);
   assign s6_prev_month = (s5_month_ff == JANUARY) ? DECEMBER : s5_month_ff - 4'd1;

   always_comb begin
      s6_year_in   = s5_year_ff;
      s6_month_in  = s5_month_ff;
      s6_mday_in   = s5_mday_ff;
      s6_hour_wrap = s5_hour_ff;
      if (!s5_hour_ff[6] && (s5_hour_ff >= HOURS_PER_DAY)) begin
         // past midnight: next day
         s6_hour_wrap = s5_hour_ff - HOURS_PER_DAY;
         if (s5_mday_ff >= month_len(s5_month_ff, s6_leap)) begin
            s6_mday_in = 5'd1;
            if (s5_month_ff == DECEMBER) begin
               s6_month_in = JANUARY;
               s6_year_in  = s5_year_ff + 12'd1;
            end else begin
               s6_month_in = s5_month_ff + 4'd1;
            end
         end else begin
            s6_mday_in = s5_mday_ff + 5'd1;
         end
      end else if (s5_hour_ff[6]) begin
         // before midnight: previous day
         s6_hour_wrap = s5_hour_ff + HOURS_PER_DAY;
         if (s5_mday_ff <= 5'd1) begin
            s6_month_in = s6_prev_month;
            if (s5_month_ff == JANUARY) begin
               s6_year_in = s5_year_ff - 12'd1;
            end
            s6_mday_in = month_len(s6_prev_month, s6_leap);
         end else begin
            s6_mday_in = s5_mday_ff - 5'd1;
         end
      end
   end

   // rejected replies give an all-zero item
   always_comb begin
      s6_hour_in = s6_hour_wrap[4:0];
      s6_min_in  = s5_min_ff;
      s6_sec_in  = s5_sec_ff;
      s6_wday_in = s5_wday_ff;
      s6_yday_in = s5_yday_ff;
      if (!s5_acc_ff) begin
         s6_hour_in = '0;
         s6_min_in  = '0;
         s6_sec_in  = '0;
         s6_wday_in = '0;
         s6_yday_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.load[6]) begin
         s6_acc_ff   <= s5_acc_ff;
         s6_year_ff  <= s5_acc_ff ? s6_year_in  : 12'd0;
         s6_month_ff <= s5_acc_ff ? s6_month_in : 4'd0;
         s6_mday_ff  <= s5_acc_ff ? s6_mday_in  : 5'd0;
         s6_hour_ff  <= s6_hour_in;
         s6_min_ff   <= s6_min_in;
         s6_sec_ff   <= s6_sec_in;
         s6_wday_ff  <= s6_wday_in;
         s6_yday_ff  <= s6_yday_in;
      end
   end

   assign out_accepted = s6_acc_ff;
   assign out_year     = s6_year_ff;
   assign out_month    = s6_month_ff;
   assign out_day      = s6_mday_ff;
   assign out_hour     = s6_hour_ff;
   assign out_minute   = s6_min_ff;
   assign out_second   = s6_sec_ff;
   assign out_weekday  = s6_wday_ff;
   assign out_yearday  = s6_yday_ff;

endmodule

// ===== dv/tb.sv =====
// Testbench for ntp_seconds_to_local_calendar_unit: a directed table of replies, then
// random replies under several zone settings, checked against a calendar predictor or,
// for typed rows, the table's own item. Depends on ntpc_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb
   import ntpc_pkg::*;
();

   // SNTP modes that the unit must reject
   localparam logic [2:0] MODE_RESERVED    = 3'd0;
   localparam logic [2:0] MODE_SYM_ACTIVE  = 3'd1;
   localparam logic [2:0] MODE_SYM_PASSIVE = 3'd2;
   localparam logic [2:0] MODE_CLIENT      = 3'd3;
   localparam logic [2:0] MODE_CONTROL     = 3'd6;
   localparam logic [2:0] MODE_PRIVATE     = 3'd7;

   localparam logic [31:0] EPOCH_1970_NTP = 32'd2208988800;
   localparam int unsigned SECS_IN_DAY    = 86400;
   localparam int          CYCLE_LIMIT    = 1000000;
   localparam int          RANDOM_PHASES  = 8;
   localparam int          ITEMS_PER_PHASE = 250;

   // one calendar item as {tuser, tdata[49:0]}
   typedef struct packed {
      logic       accepted;
      logic [8:0] yearday;
      logic [2:0] weekday;
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
      logic [11:0] year;
   } calendar_type;

   typedef struct {
      int           zone;
      bit           dst;
      logic [2:0]   mode;
      logic [31:0]  secs;
      bit           typed;
      calendar_type want;
   } reply_row_type;

   localparam calendar_type EPOCH_UTC = '{accepted: 1'b1, yearday: 9'd0, weekday: 3'd4,
                                          second: 6'd0, minute: 6'd0, hour: 5'd0,
                                          day: 5'd1, month: 4'd1, year: 12'd1970};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;     // [31:0] ntp_seconds
   logic [2:0]  req_tuser = '0;     // [2:0] mode_bits
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // [11:0] year .. [49:41] yearday, [55:50] zero
   logic        rsp_tuser;         // [0] accepted

   // shadow of the unit's registers
   logic signed [4:0] zone_hours = '0;
   logic              dst_hour = 1'b0;

   calendar_type  calendars_due[$];
   reply_row_type reply_table[$];
   int            errors = 0;
   int            cycles = 0;
   bit            free_run = 1'b0;
   int            ready_hold = 0;
   int            ready_pick;

   ntp_seconds_to_local_calendar_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int leap_day(int y);
      return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 1 : 0;
   endfunction

   function automatic int days_in_month(int m, int y);
      if (m == 2) begin
         return 28 + leap_day(y);
      end
      return (m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31;
   endfunction

   // NTP seconds for a UTC date and time from 1970 on
   function automatic logic [31:0] ntp_at(int y, int mo, int d, int h, int mi, int s);
      longint total;
      total = d - 1;
      for (int yy = 1970; yy < y; yy++) total += 365 + leap_day(yy);
      for (int mm = 1; mm < mo; mm++) total += days_in_month(mm, y);
      total = total * SECS_IN_DAY + h * 3600 + mi * 60 + s + EPOCH_1970_NTP;
      return total[31:0];
   endfunction

   // local calendar item for one reply under the current zone and daylight hour
   function automatic calendar_type predict_calendar(logic [2:0] mode, logic [31:0] secs);
      calendar_type cal;
      logic [31:0]  unix_s;
      int unsigned  days;
      int unsigned  rem;
      int           y;
      int           m;
      int           d;
      int           h;
      cal = '0;
      if (mode != MODE_SERVER && mode != MODE_BROADCAST) begin
         return cal;
      end
      unix_s = secs - EPOCH_1970_NTP;
      days = unix_s / SECS_IN_DAY;
      rem = unix_s % SECS_IN_DAY;
      cal.minute = 6'((rem % 3600) / 60);
      cal.second = 6'(rem % 60);
      cal.weekday = 3'((days + 4) % 7);
      y = 1970;
      while (days >= 365 + leap_day(y)) begin
         days -= 365 + leap_day(y);
         y++;
      end
      cal.yearday = 9'(days);
      m = 1;
      while (m < 12 && days >= days_in_month(m, y)) begin
         days -= days_in_month(m, y);
         m++;
      end
      d = days + 1;
      h = int'(rem / 3600) + int'(zone_hours) + int'(dst_hour);
      // local hour past midnight: step the date one day forward
      if (h >= 24) begin
         h -= 24;
         if (d >= days_in_month(m, y)) begin
            d = 1;
            if (m == 12) begin
               m = 1;
               y++;
            end else begin
               m++;
            end
         end else begin
            d++;
         end
      // local hour before midnight: step the date one day back
      end else if (h < 0) begin
         h += 24;
         if (d <= 1) begin
            if (m == 1) begin
               m = 12;
               y--;
            end else begin
               m--;
            end
            d = days_in_month(m, y);
         end else begin
            d--;
         end
      end
      cal.accepted = 1'b1;
      cal.year = 12'(y);
      cal.month = 4'(m);
      cal.day = 5'(d);
      cal.hour = 5'(h);
      return cal;
   endfunction

   function automatic int sender_gap();
      int pick;
      pick = $urandom_range(99);
      if (free_run || pick < 50) begin
         return 0;
      end else if (pick < 85) begin
         return $urandom_range(1, 3);
      end else if (pick < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // receiver stalls: mostly short, a few long, none while free running
   always @(posedge clock) begin
      if (free_run) begin
         rsp_tready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold == 0) begin
         ready_pick = $urandom_range(99);
         if (ready_pick < 55) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(1, 30);
         end else if (ready_pick < 95) begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(1, 3);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(10, 40);
         end
      end else begin
         ready_hold <= ready_hold - 1;
      end
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // compare each calendar item with the oldest one due
   always @(posedge clock) begin
      calendar_type got;
      calendar_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[49:0]};
         if (calendars_due.size() == 0) begin
            $error("calendar item with nothing due");
            errors++;
         end else begin
            want = calendars_due.pop_front();
            check_field("accepted", want.accepted, got.accepted);
            check_field("year", want.year, got.year);
            check_field("month", want.month, got.month);
            check_field("day", want.day, got.day);
            check_field("hour", want.hour, got.hour);
            check_field("minute", want.minute, got.minute);
            check_field("second", want.second, got.second);
            check_field("weekday", want.weekday, got.weekday);
            check_field("yearday", want.yearday, got.yearday);
         end
      end
   end

   // offer one reply until taken, then queue its calendar item
   task automatic send_reply(logic [2:0] mode, logic [31:0] secs, calendar_type want);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= secs;
      req_tuser <= mode;
      do @(posedge clock); while (!req_tready);
      calendars_due.push_back(want);
   endtask

   // write a register, then read it back
   task automatic program_reg(ntpc_reg_type idx, logic [31:0] value);
      logic [31:0] mask;
      mask = (idx == REG_UTC_OFFSET) ? 32'h1F : 32'h1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if ((csr_prdata & mask) != (value & mask)) begin
         $error("readback %s: expected %0h, got %0h", idx.name(), value & mask,
                csr_prdata & mask);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // let every item drain, then program zone and daylight hour
   task automatic apply_zone(int zone, bit dst);
      req_tvalid <= 1'b0;
      while (calendars_due.size() != 0) @(posedge clock);
      repeat (NUM_STAGES) @(posedge clock);
      program_reg(REG_UTC_OFFSET, 32'(zone & 31));
      program_reg(REG_DAYLIGHT, 32'(dst));
      zone_hours = 5'(zone);
      dst_hour = dst;
   endtask

   task automatic add_row(int zone, bit dst, logic [2:0] mode, logic [31:0] secs,
                          bit typed, calendar_type want);
      reply_table.push_back('{zone, dst, mode, secs, typed, want});
   endtask

   function automatic logic [31:0] random_secs();
      int y;
      int mo;
      int d;
      int h;
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom;
         8: return EPOCH_1970_NTP - 32'd100000 + $urandom_range(0, 200000);
         9: return $urandom_range(1) ? 32'($urandom_range(0, 200000))
                                     : 32'hFFFFFFFF - $urandom_range(0, 200000);
         default: begin
            // dates near month and day boundaries, where the zone shift rolls over
            y = $urandom_range(1970, 2105);
            mo = $urandom_range(1, 12);
            case ($urandom_range(2))
               0: d = 1;
               1: d = days_in_month(mo, y);
               default: d = $urandom_range(1, days_in_month(mo, y));
            endcase
            h = $urandom_range(3) == 0 ? $urandom_range(0, 23)
              : ($urandom_range(1) ? $urandom_range(0, 2) : $urandom_range(21, 23));
            return ntp_at(y, mo, d, h, $urandom_range(0, 59), $urandom_range(0, 59));
         end
      endcase
   endfunction

   initial begin
      logic [2:0] mode;
      logic [31:0] secs;
      int zone;
      bit dst;

      // directed replies: rejected modes, era edges, rollovers at every zone extreme
      add_row(0, 0, MODE_SERVER, ntp_at(1970, 1, 1, 0, 0, 0), 1, EPOCH_UTC);
      add_row(0, 0, MODE_RESERVED, 32'hFFFFFFFF, 1, '0);
      add_row(0, 0, MODE_SYM_ACTIVE, 32'h0, 1, '0);
      add_row(0, 0, MODE_SYM_PASSIVE, ntp_at(2000, 2, 29, 12, 0, 0), 1, '0);
      add_row(0, 0, MODE_CLIENT, 32'h55555555, 1, '0);
      add_row(0, 0, MODE_CONTROL, 32'hAAAAAAAA, 1, '0);
      add_row(0, 0, MODE_PRIVATE, ntp_at(1970, 1, 1, 0, 0, 0), 1, '0);
      add_row(0, 0, MODE_BROADCAST, 32'h0, 0, '0);
      add_row(0, 0, MODE_SERVER, 32'hFFFFFFFF, 0, '0);
      add_row(0, 0, MODE_BROADCAST, EPOCH_1970_NTP - 32'd1, 0, '0);
      add_row(0, 0, MODE_SERVER, ntp_at(2016, 12, 31, 23, 59, 59), 0, '0);
      add_row(-12, 0, MODE_SERVER, ntp_at(1970, 1, 1, 0, 0, 0), 0, '0);
      add_row(-12, 0, MODE_BROADCAST, ntp_at(2000, 3, 1, 5, 30, 0), 0, '0);
      add_row(-12, 0, MODE_SERVER, ntp_at(2100, 3, 1, 11, 0, 0), 0, '0);
      add_row(-12, 0, MODE_SERVER, ntp_at(2019, 3, 1, 0, 0, 0), 0, '0);
      add_row(-12, 0, MODE_SERVER, ntp_at(2021, 5, 1, 12, 0, 0), 0, '0);
      add_row(14, 1, MODE_SERVER, ntp_at(2105, 12, 31, 23, 0, 0), 0, '0);
      add_row(14, 1, MODE_BROADCAST, ntp_at(2024, 2, 28, 10, 0, 0), 0, '0);
      add_row(14, 1, MODE_SERVER, ntp_at(2100, 2, 28, 9, 0, 0), 0, '0);
      add_row(14, 1, MODE_SERVER, ntp_at(2023, 4, 30, 8, 59, 59), 0, '0);
      add_row(15, 0, MODE_SERVER, ntp_at(2023, 1, 31, 20, 0, 0), 0, '0);
      add_row(-16, 0, MODE_BROADCAST, ntp_at(2023, 1, 1, 3, 0, 0), 0, '0);
      add_row(-16, 1, MODE_SERVER, ntp_at(2023, 8, 1, 15, 0, 0), 0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (reply_table[i]) begin
         if (5'(reply_table[i].zone) != zone_hours || reply_table[i].dst != dst_hour) begin
            apply_zone(reply_table[i].zone, reply_table[i].dst);
         end
         send_reply(reply_table[i].mode, reply_table[i].secs,
                    reply_table[i].typed ? reply_table[i].want
                    : predict_calendar(reply_table[i].mode, reply_table[i].secs));
      end

      // random replies, one zone setting per phase, extremes first
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin zone = 0;   dst = 0; end
            1: begin zone = -12; dst = 0; end
            2: begin zone = 14;  dst = 1; end
            3: begin zone = -16; dst = 1; end
            4: begin zone = 15;  dst = 0; end
            default: begin
               zone = $urandom_range(0, 31) - 16;
               dst = $urandom_range(1);
            end
         endcase
         apply_zone(zone, dst);
         free_run = (phase == 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            mode = ($urandom_range(9) < 8) ? ($urandom_range(1) ? MODE_SERVER : MODE_BROADCAST)
                                           : 3'($urandom_range(0, 7));
            secs = random_secs();
            send_reply(mode, secs, predict_calendar(mode, secs));
         end
         free_run = 1'b0;
      end

      req_tvalid <= 1'b0;
      while (calendars_due.size() != 0) @(posedge clock);
      repeat (2 * NUM_STAGES) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
